// File: rtl/psa_pkg.sv
package psa_pkg;

   localparam int ARCH_DEPTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int SCORE_W  = FRAC_BITS + 1;
   localparam int IDX_W    = $clog2(ARCH_DEPTH);
   localparam int CNT_W    = $clog2(ARCH_DEPTH + 1);
   localparam int STATUS_W = 3;

   localparam int REQ_DATA_BITS = 3 * SCORE_W;
   localparam int REQ_DATA_W    = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = IDX_W + CNT_W + 6 * SCORE_W;
   localparam int RSP_DATA_W    = ((RSP_DATA_BITS + 7) / 8) * 8;

   typedef logic [SCORE_W-1:0]  score_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam score_type SCORE_ONE = score_type'(1) << FRAC_BITS;

   localparam status_type STAT_ADDED       = 3'd0;
   localparam status_type STAT_DUPLICATE   = 3'd1;
   localparam status_type STAT_FULL        = 3'd2;
   localparam status_type STAT_FRONT_INDEX = 3'd3;
   localparam status_type STAT_FRONT_EMPTY = 3'd4;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_FRONT  = 1'b1;

   typedef struct packed {
      score_type cov;
      score_type fea;
      score_type var_s;
   } triple_type;

   // item traveling down the row of cells
   typedef struct packed {
      logic       valid;
      logic       is_query;
      logic       live;
      logic       is_end;
      idx_type    idx;
      triple_type triple;
      logic       hit;
      idx_type    hit_idx;
   } probe_type;

   typedef struct packed {
      logic       en;
      idx_type    addr;
      triple_type triple;
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   function automatic score_type sat_score(input score_type v);
      return (v > SCORE_ONE) ? SCORE_ONE : v;
   endfunction

   // j dominates i
   function automatic logic dominates(input triple_type j, input triple_type i);
      return (i.cov <= j.cov) && (i.fea <= j.fea) && (i.var_s >= j.var_s);
   endfunction

endpackage

// File: rtl/psa_cell.sv
module psa_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  psa_pkg::idx_type       cell_idx,
   input  psa_pkg::cnt_type       count,
   input  psa_pkg::wr_type        wr,
   input  psa_pkg::probe_type     probe_in,
   output psa_pkg::probe_type     probe_out,
   output psa_pkg::triple_type    entry
);

   psa_pkg::triple_type entry_ff;
   psa_pkg::probe_type  probe_ff;
   psa_pkg::probe_type  probe_in_c;
   logic                in_use;

   assign in_use = psa_pkg::CNT_W'(cell_idx) < count;

   always_comb begin
      probe_in_c = probe_in;
      if (probe_in.valid && in_use) begin
         if (!probe_in.is_query) begin
            if (!probe_in.hit && (entry_ff == probe_in.triple)) begin
               probe_in_c.hit     = 1'b1;
               probe_in_c.hit_idx = cell_idx;
            end
         end else begin
            if ((probe_in.idx != cell_idx) && psa_pkg::dominates(entry_ff, probe_in.triple)) begin
               probe_in_c.hit = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else if (adv) begin
         probe_ff <= probe_in_c;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == cell_idx)) begin
         entry_ff <= wr.triple;
      end
   end

   assign probe_out = probe_ff;
   assign entry     = entry_ff;

endmodule

// File: rtl/psa_ctrl.sv
module psa_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,
   input  logic [psa_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psa_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic [psa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              adv,
   output psa_pkg::cnt_type                  count,
   output psa_pkg::wr_type                   wr,
   output psa_pkg::probe_type                launch,
   input  psa_pkg::probe_type                tail,
   input  psa_pkg::triple_type               entries [psa_pkg::ARCH_DEPTH]
);

   psa_pkg::state_type  state_ff, state_in;
   psa_pkg::cnt_type    count_ff, count_in;
   psa_pkg::triple_type min_ff, min_in;
   psa_pkg::triple_type max_ff, max_in;
   psa_pkg::idx_type    launch_idx_ff, launch_idx_in;
   logic                held_valid_ff, held_valid_in;
   psa_pkg::idx_type    held_idx_ff, held_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   psa_pkg::status_type rsp_status_ff;
   psa_pkg::idx_type    rsp_idx_ff;
   psa_pkg::cnt_type    rsp_count_ff;
   logic                rsp_last_ff;
   psa_pkg::triple_type rsp_min_ff, rsp_max_ff;

   logic                accept;
   logic                tail_event;
   logic                emit;
   psa_pkg::status_type emit_status;
   psa_pkg::idx_type    emit_idx;
   logic                emit_last;
   psa_pkg::triple_type req_triple;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == psa_pkg::ST_IDLE) && adv;
   assign accept     = req_tvalid && req_tready;
   assign tail_event = adv && tail.valid;
   assign count      = count_ff;

   assign req_triple.cov   = psa_pkg::sat_score(
      req_tdata[psa_pkg::SCORE_W-1:0]);
   assign req_triple.fea   = psa_pkg::sat_score(
      req_tdata[2*psa_pkg::SCORE_W-1:psa_pkg::SCORE_W]);
   assign req_triple.var_s = psa_pkg::sat_score(
      req_tdata[3*psa_pkg::SCORE_W-1:2*psa_pkg::SCORE_W]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psa_pkg::ST_IDLE: begin
            if (accept) begin
               if ((req_tuser == psa_pkg::KIND_FRONT) && (count_ff > psa_pkg::CNT_W'(1))) begin
                  state_in = psa_pkg::ST_LAUNCH;
               end else begin
                  state_in = psa_pkg::ST_DRAIN;
               end
            end
         end
         psa_pkg::ST_LAUNCH: begin
            if (adv && ((psa_pkg::CNT_W'(launch_idx_ff) + psa_pkg::CNT_W'(1)) == count_ff)) begin
               state_in = psa_pkg::ST_DRAIN;
            end
         end
         psa_pkg::ST_DRAIN: begin
            if (tail_event && tail.is_end) begin
               state_in = tail.is_query ? psa_pkg::ST_FLUSH : psa_pkg::ST_IDLE;
            end
         end
         psa_pkg::ST_FLUSH: begin
            if (adv) begin
               state_in = psa_pkg::ST_IDLE;
            end
         end
         default: state_in = psa_pkg::ST_IDLE;
      endcase
   end

   // launch, tail handling, emission
   always_comb begin
      launch        = '0;
      launch_idx_in = launch_idx_ff;
      wr            = '0;
      count_in      = count_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      held_valid_in = held_valid_ff;
      held_idx_in   = held_idx_ff;
      emit          = 1'b0;
      emit_status   = psa_pkg::STAT_ADDED;
      emit_idx      = '0;
      emit_last     = 1'b1;

      case (state_ff)
         psa_pkg::ST_IDLE: begin
            if (accept) begin
               launch.valid    = 1'b1;
               launch.is_query = req_tuser;
               launch.is_end   = 1'b1;
               launch.live     = 1'b1;
               launch.triple   = req_triple;
               if (req_tuser == psa_pkg::KIND_FRONT) begin
                  launch.triple = entries[0];
                  launch_idx_in = psa_pkg::IDX_W'(1);
                  held_valid_in = 1'b0;
                  if (count_ff == '0) begin
                     launch.live = 1'b0;
                  end else begin
                     launch.is_end = (count_ff == psa_pkg::CNT_W'(1));
                  end
               end
            end
         end
         psa_pkg::ST_LAUNCH: begin
            if (adv) begin
               launch.valid    = 1'b1;
               launch.is_query = 1'b1;
               launch.live     = 1'b1;
               launch.idx      = launch_idx_ff;
               launch.triple   = entries[launch_idx_ff];
               launch.is_end   =
                  (psa_pkg::CNT_W'(launch_idx_ff) + psa_pkg::CNT_W'(1)) == count_ff;
               launch_idx_in   = launch_idx_ff + psa_pkg::IDX_W'(1);
            end
         end
         psa_pkg::ST_FLUSH: begin
            if (adv) begin
               emit          = 1'b1;
               emit_last     = 1'b1;
               held_valid_in = 1'b0;
               if (held_valid_ff) begin
                  emit_status = psa_pkg::STAT_FRONT_INDEX;
                  emit_idx    = held_idx_ff;
               end else begin
                  emit_status = psa_pkg::STAT_FRONT_EMPTY;
               end
            end
         end
         default: begin
         end
      endcase

      if (tail_event) begin
         if (!tail.is_query) begin
            emit = 1'b1;
            if (tail.hit) begin
               emit_status = psa_pkg::STAT_DUPLICATE;
               emit_idx    = tail.hit_idx;
            end else if (count_ff == psa_pkg::CNT_W'(psa_pkg::ARCH_DEPTH)) begin
               emit_status = psa_pkg::STAT_FULL;
            end else begin
               emit_status  = psa_pkg::STAT_ADDED;
               emit_idx     = count_ff[psa_pkg::IDX_W-1:0];
               wr.en        = 1'b1;
               wr.addr      = count_ff[psa_pkg::IDX_W-1:0];
               wr.triple    = tail.triple;
               count_in     = count_ff + psa_pkg::CNT_W'(1);
               if (tail.triple.cov < min_ff.cov)     min_in.cov   = tail.triple.cov;
               if (tail.triple.cov > max_ff.cov)     max_in.cov   = tail.triple.cov;
               if (tail.triple.fea < min_ff.fea)     min_in.fea   = tail.triple.fea;
               if (tail.triple.fea > max_ff.fea)     max_in.fea   = tail.triple.fea;
               if (tail.triple.var_s < min_ff.var_s) min_in.var_s = tail.triple.var_s;
               if (tail.triple.var_s > max_ff.var_s) max_in.var_s = tail.triple.var_s;
            end
         end else if (tail.live && !tail.hit) begin
            // one result held back so the final one can carry last
            if (held_valid_ff) begin
               emit        = 1'b1;
               emit_status = psa_pkg::STAT_FRONT_INDEX;
               emit_idx    = held_idx_ff;
               emit_last   = 1'b0;
            end
            held_valid_in = 1'b1;
            held_idx_in   = tail.idx;
         end
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= psa_pkg::ST_IDLE;
         count_ff      <= '0;
         min_ff        <= '{psa_pkg::SCORE_ONE, psa_pkg::SCORE_ONE, psa_pkg::SCORE_ONE};
         max_ff        <= '0;
         launch_idx_ff <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         launch_idx_ff <= launch_idx_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_idx_ff <= held_idx_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_idx_ff    <= emit_idx;
         rsp_count_ff  <= count_in;
         rsp_last_ff   <= emit_last;
         rsp_min_ff    <= min_in;
         rsp_max_ff    <= max_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = psa_pkg::RSP_DATA_W'({rsp_max_ff.var_s, rsp_min_ff.var_s,
                                             rsp_max_ff.fea, rsp_min_ff.fea,
                                             rsp_max_ff.cov, rsp_min_ff.cov,
                                             rsp_count_ff, rsp_idx_ff});

endmodule

// File: rtl/pareto_score_archive_top.sv
// Pareto score archive: up to 32 (coverage, feasibility, variation) triples in Q1.16, one per
// cell of a row. Every item travels the whole row, one cell per cycle, and the row only moves
// while the result register is free. An insert (tuser 0) loads a single result into the output
// register: duplicate check in the cells, then append and bound update at the end of the row.
// A front query (tuser 1) sends one probe per stored entry, one per cycle while the row moves,
// each checked for dominance against every other stored entry; its results come in index order
// with tlast on the final one. An empty archive answers a query with one front-empty result.
// Scores above 1.0 are saturated to 1.0 on insert. A new item is taken at the earliest in the
// cycle after the final result of the previous one is loaded; a waiting result that is not
// taken stops the row.
module pareto_score_archive_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,   // kind
   input  logic [psa_pkg::REQ_DATA_W-1:0]    req_tdata,   // cov_score, fea_score, var_score
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psa_pkg::STATUS_W-1:0]      rsp_tuser,   // status
   // entry_index, entry_count, cov_min, cov_max, fea_min, fea_max, var_min, var_max
   output logic [psa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);

   logic                adv;
   psa_pkg::cnt_type    count;
   psa_pkg::wr_type     wr;
   psa_pkg::probe_type  link [psa_pkg::ARCH_DEPTH+1];
   psa_pkg::triple_type entries [psa_pkg::ARCH_DEPTH];

   psa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .adv        (adv),
      .count      (count),
      .wr         (wr),
      .launch     (link[0]),
      .tail       (link[psa_pkg::ARCH_DEPTH]),
      .entries    (entries)
   );

   for (genvar k = 0; k < psa_pkg::ARCH_DEPTH; k++) begin : g_cell
      psa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .cell_idx  (psa_pkg::IDX_W'(k)),
         .count     (count),
         .wr        (wr),
         .probe_in  (link[k]),
         .probe_out (link[k+1]),
         .entry     (entries[k])
      );
   end

endmodule

// File: dv/psa_tb_pkg.sv
package psa_tb_pkg;

   import psa_pkg::*;

   // bit offsets inside rsp_tdata
   localparam int CNT_LO  = IDX_W;
   localparam int CMIN_LO = IDX_W + CNT_W;
   localparam int CMAX_LO = CMIN_LO + SCORE_W;
   localparam int FMIN_LO = CMAX_LO + SCORE_W;
   localparam int FMAX_LO = FMIN_LO + SCORE_W;
   localparam int VMIN_LO = FMAX_LO + SCORE_W;
   localparam int VMAX_LO = VMIN_LO + SCORE_W;

   typedef struct packed {
      status_type status;
      idx_type    index;
      cnt_type    count;
      logic       is_last;
      score_type  lo_cov;
      score_type  hi_cov;
      score_type  lo_fea;
      score_type  hi_fea;
      score_type  lo_var;
      score_type  hi_var;
   } archive_result_t;

   function automatic archive_result_t unpack_result(input status_type st,
                                                     input logic [RSP_DATA_W-1:0] d,
                                                     input logic lst);
      archive_result_t r;
      r.status  = st;
      r.index   = d[IDX_W-1:0];
      r.count   = d[CNT_LO +: CNT_W];
      r.is_last = lst;
      r.lo_cov  = d[CMIN_LO +: SCORE_W];
      r.hi_cov  = d[CMAX_LO +: SCORE_W];
      r.lo_fea  = d[FMIN_LO +: SCORE_W];
      r.hi_fea  = d[FMAX_LO +: SCORE_W];
      r.lo_var  = d[VMIN_LO +: SCORE_W];
      r.hi_var  = d[VMAX_LO +: SCORE_W];
      return r;
   endfunction

   class archive_scoreboard;
      triple_type      store [ARCH_DEPTH];
      int unsigned     count;
      triple_type      lo_bound;
      triple_type      hi_bound;
      archive_result_t pending [$];
      int unsigned     errors;
      int unsigned     checked;

      function new();
         count    = 0;
         lo_bound = {SCORE_ONE, SCORE_ONE, SCORE_ONE};
         hi_bound = '0;
         errors   = 0;
         checked  = 0;
      endfunction

      function score_type clip(input score_type s);
         return (s > SCORE_ONE) ? SCORE_ONE : s;
      endfunction

      // a beats b: coverage and feasibility no lower, variation no higher
      function bit beats(input triple_type a, input triple_type b);
         return (a.cov >= b.cov) && (a.fea >= b.fea) && (a.var_s <= b.var_s);
      endfunction

      function void push(input status_type st, input int unsigned idx, input logic lst);
         archive_result_t r;
         r.status  = st;
         r.index   = idx_type'(idx);
         r.count   = cnt_type'(count);
         r.is_last = lst;
         r.lo_cov  = lo_bound.cov;
         r.hi_cov  = hi_bound.cov;
         r.lo_fea  = lo_bound.fea;
         r.hi_fea  = hi_bound.fea;
         r.lo_var  = lo_bound.var_s;
         r.hi_var  = hi_bound.var_s;
         pending = {pending, r};
      endfunction

      task note_item(input logic kind, input score_type c, input score_type f,
                     input score_type v);
         triple_type t;
         int         dup;
         int         front [$];
         bit         beaten;
         if (kind == KIND_INSERT) begin
            t.cov   = clip(c);
            t.fea   = clip(f);
            t.var_s = clip(v);
            dup = -1;
            for (int i = 0; i < count; i++) begin
               if (dup < 0 && store[i] == t) dup = i;
            end
            if (dup >= 0) begin
               push(STAT_DUPLICATE, dup, 1'b1);
            end else if (count >= ARCH_DEPTH) begin
               push(STAT_FULL, 0, 1'b1);
            end else begin
               store[count] = t;
               if (t.cov < lo_bound.cov) lo_bound.cov = t.cov;
               if (t.cov > hi_bound.cov) hi_bound.cov = t.cov;
               if (t.fea < lo_bound.fea) lo_bound.fea = t.fea;
               if (t.fea > hi_bound.fea) hi_bound.fea = t.fea;
               if (t.var_s < lo_bound.var_s) lo_bound.var_s = t.var_s;
               if (t.var_s > hi_bound.var_s) hi_bound.var_s = t.var_s;
               count++;
               push(STAT_ADDED, count - 1, 1'b1);
            end
         end else begin
            for (int i = 0; i < count; i++) begin
               beaten = 1'b0;
               for (int j = 0; j < count; j++) begin
                  if (j != i && beats(store[j], store[i])) beaten = 1'b1;
               end
               if (!beaten) front = {front, i};
            end
            if (front.size() == 0) begin
               push(STAT_FRONT_EMPTY, 0, 1'b1);
            end else begin
               foreach (front[k]) push(STAT_FRONT_INDEX, front[k], k == front.size() - 1);
            end
         end
      endtask

      task report(input string what, input int got, input int want);
         errors++;
         if (errors <= 60)
            $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, checked, got, want);
      endtask

      task check_result(input archive_result_t got);
         archive_result_t want;
         if (pending.size() == 0) begin
            report("unexpected item", got.status, 0);
            return;
         end
         want = pending.pop_front();
         if (got.status != want.status) report("status", got.status, want.status);
         if (got.index != want.index) report("entry_index", got.index, want.index);
         if (got.count != want.count) report("entry_count", got.count, want.count);
         if (got.is_last != want.is_last) report("last", got.is_last, want.is_last);
         if (got.lo_cov != want.lo_cov) report("cov_min", got.lo_cov, want.lo_cov);
         if (got.hi_cov != want.hi_cov) report("cov_max", got.hi_cov, want.hi_cov);
         if (got.lo_fea != want.lo_fea) report("fea_min", got.lo_fea, want.lo_fea);
         if (got.hi_fea != want.hi_fea) report("fea_max", got.hi_fea, want.hi_fea);
         if (got.lo_var != want.lo_var) report("var_min", got.lo_var, want.lo_var);
         if (got.hi_var != want.hi_var) report("var_max", got.hi_var, want.hi_var);
         checked++;
      endtask
   endclass

endpackage

// File: dv/tb_pareto_score_archive_top.sv
module tb_pareto_score_archive_top;

   timeunit 1ns;
   timeprecision 1ps;

   import psa_pkg::*;
   import psa_tb_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic                  req_tuser;    // kind
   logic [REQ_DATA_W-1:0] req_tdata;    // cov_score, fea_score, var_score
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [STATUS_W-1:0]   rsp_tuser;    // status
   // entry_index, entry_count, cov_min, cov_max, fea_min, fea_max, var_min, var_max
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   archive_scoreboard sb;
   int unsigned       cycle_count = 0;
   int unsigned       burst_left  = 0;

   pareto_score_archive_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_result(unpack_result(rsp_tuser, rsp_tdata, rsp_tlast));
   end

   // receiver: phases of always-ready, coin flip, heavy stall and a fixed duty cycle
   initial begin
      int mode;
      int left;
      int tick;
      mode = 0;
      left = 0;
      tick = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(8, 160);
         end
         left--;
         tick++;
         case (mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
               rsp_tready <= (tick % 4 != 3);
            end
         endcase
      end
   end

   function automatic score_type pick_score();
      int unsigned r;
      r = $urandom_range(0, 19);
      case (r)
         0: return '0;
         1: return SCORE_ONE;
         2: return score_type'($urandom_range(65537, 131071));
         3, 4: return score_type'(16384 * $urandom_range(0, 4));
         5: return score_type'(65535);
         default: return score_type'($urandom_range(0, 65536));
      endcase
   endfunction

   // 1.0 may also be sent as any raw value of 1.0 or above
   function automatic score_type alias_one(input score_type s);
      if (s == SCORE_ONE && $urandom_range(0, 1) == 1)
         return score_type'($urandom_range(65536, 131071));
      return s;
   endfunction

   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_item(input logic kind, input score_type c, input score_type f,
                            input score_type v);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({v, f, c});
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_item(kind, c, f, v);
      pace();
   endtask

   task automatic drain_pending();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned r;
      triple_type  t;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         send_item(KIND_FRONT, score_type'($urandom), score_type'($urandom),
                   score_type'($urandom));
      end else if (r < 45 && sb.count > 0) begin
         t = sb.store[$urandom_range(0, sb.count - 1)];
         send_item(KIND_INSERT, alias_one(t.cov), alias_one(t.fea), alias_one(t.var_s));
      end else if (r < 53 && sb.count > 0) begin
         // one bit away from a stored entry
         t = sb.store[$urandom_range(0, sb.count - 1)];
         case ($urandom_range(0, 2))
            0: t.cov[0] = ~t.cov[0];
            1: t.fea[0] = ~t.fea[0];
            default: t.var_s[0] = ~t.var_s[0];
         endcase
         send_item(KIND_INSERT, t.cov, t.fea, t.var_s);
      end else begin
         send_item(KIND_INSERT, pick_score(), pick_score(), pick_score());
      end
   endtask

   initial begin
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= KIND_INSERT;
      req_tdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty archive, duplicates, saturation, dominance and ties
      send_item(KIND_FRONT, '0, '0, '0);
      send_item(KIND_INSERT, '0, '0, '0);
      send_item(KIND_INSERT, '0, '0, '0);
      send_item(KIND_FRONT, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      send_item(KIND_INSERT, SCORE_ONE, SCORE_ONE, '0);
      send_item(KIND_FRONT, '0, '0, '0);
      send_item(KIND_INSERT, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      send_item(KIND_INSERT, SCORE_ONE, SCORE_ONE, SCORE_ONE);
      send_item(KIND_INSERT, 17'h10001, '0, 17'h1FFFF);
      send_item(KIND_INSERT, '0, 17'h1FFFF, '0);
      send_item(KIND_INSERT, 17'd65535, SCORE_ONE, '0);
      send_item(KIND_INSERT, 17'h15555, 17'h0AAAA, 17'h0AAAA);
      send_item(KIND_FRONT, 17'h15555, 17'h0AAAA, 17'h15555);
      send_item(KIND_INSERT, 17'h0AAAA, 17'h15555, 17'h15555);
      send_item(KIND_INSERT, 17'd32768, 17'd32768, 17'd32768);
      send_item(KIND_INSERT, 17'd32768, 17'd32768, 17'd16384);
      send_item(KIND_INSERT, 17'd32768, 17'd16384, 17'd16384);
      send_item(KIND_INSERT, 17'd16384, 17'd32768, 17'd16384);
      send_item(KIND_INSERT, 17'd65535, 17'd1, 17'd0);
      send_item(KIND_FRONT, '0, '0, '0);
      drain_pending();

      for (int n = 0; n < 135; n++) begin
         if (n == 70) drain_pending();
         random_item();
      end

      // top up to full, then full, duplicate while full, and a full-size query
      while (sb.count < ARCH_DEPTH)
         send_item(KIND_INSERT, pick_score(), pick_score(), pick_score());
      send_item(KIND_INSERT, score_type'($urandom_range(1, 65535)), '0, SCORE_ONE);
      send_item(KIND_INSERT, sb.store[ARCH_DEPTH-1].cov, sb.store[ARCH_DEPTH-1].fea,
                sb.store[ARCH_DEPTH-1].var_s);
      send_item(KIND_FRONT, '0, '0, '0);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.pending.size() != 0) sb.report("results never came", sb.pending.size(), 0);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
